// File: sv/pfsb_pkg.sv
// Package for the point filter scan binner: types, register codes, CORDIC table.
`default_nettype none
package pfsb_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_RANGE_MIN   = 3'd0;
    localparam logic [2:0] CFG_RANGE_MAX   = 3'd1;
    localparam logic [2:0] CFG_GROUND_LOW  = 3'd2;
    localparam logic [2:0] CFG_GROUND_HIGH = 3'd3;
    localparam logic [2:0] CFG_WALL_MARGIN = 3'd4;
    localparam logic [2:0] CFG_ARENA_X_HI  = 3'd5;
    localparam logic [2:0] CFG_ARENA_Y_HI  = 3'd6;

    // Item opcodes
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam int CORDIC_STEPS = 24;
    localparam int SQRT_STEPS   = 19;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RANGE,
        ST_CALC,
        ST_BIN,
        ST_RD,
        ST_WR
    } t_state;

    // Arctangent of 2^-i as a fraction of a full turn (2^32)
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// File: sv/pfsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfsb_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 720
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/point_filter_scan_binner.sv
// Point filter scan binner top level: filters, range/angle unit, bin memory.
//
//  channel   direction  signals                                   transfer when
//  input     in         i_in_valid/o_in_ready, opcode..bin_select valid & ready
//  output    out        o_out_valid/i_out_ready, kept, range, hit valid & ready
//  config    in         i_cfg_wr_en, i_cfg_index, i_cfg_data      wr_en high
//
// A binned point holds the input through capture, filter and squares, range test,
// the shared CORDIC/square-root iteration, bin multiply, then a read and a write
// of the bin memory. An unbinned point ends after the range test, a bin read goes
// via capture, memory read and clear; a bin out of range skips the memory read.
// After reset a clearing pass writes every bin, with no input
// taken. The output register lets the next item start while a result waits;
// a finished item holds in the write state until the output register frees.
`default_nettype none
module point_filter_scan_binner
    import pfsb_pkg::*;
#(
    parameter int NUM_BINS       = 720,
    parameter int ARENA_X_LOW_MM = 0,
    parameter int ARENA_Y_LOW_MM = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [18:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_opcode,
    input  wire logic               i_point_valid,
    input  wire logic signed [18:0] i_x_mm,
    input  wire logic signed [18:0] i_y_mm,
    input  wire logic signed [18:0] i_z_mm,
    input  wire logic [9:0]         i_bin_select,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_point_kept,
    output logic [17:0]             o_bin_range_mm,
    output logic                    o_bin_hit
);
    localparam int AW = $clog2(NUM_BINS);
    localparam logic [12:0] NB = 13'(NUM_BINS);
    localparam logic signed [20:0] XL = 21'(ARENA_X_LOW_MM);
    localparam logic signed [20:0] YL = 21'(ARENA_Y_LOW_MM);

    // Configuration registers
    logic [17:0]        r_range_min, r_range_max, r_margin;
    logic signed [18:0] r_gnd_lo, r_gnd_hi, r_ax_hi, r_ay_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= 18'd100;
            r_range_max <= 18'd50000;
            r_gnd_lo    <= -19'sd50;
            r_gnd_hi    <= 19'sd50;
            r_margin    <= 18'd300;
            r_ax_hi     <= 19'sd10000;
            r_ay_hi     <= 19'sd10000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_RANGE_MIN:   r_range_min <= i_cfg_data[17:0];
                CFG_RANGE_MAX:   r_range_max <= i_cfg_data[17:0];
                CFG_GROUND_LOW:  r_gnd_lo    <= i_cfg_data;
                CFG_GROUND_HIGH: r_gnd_hi    <= i_cfg_data;
                CFG_WALL_MARGIN: r_margin    <= i_cfg_data[17:0];
                CFG_ARENA_X_HI:  r_ax_hi     <= i_cfg_data;
                CFG_ARENA_Y_HI:  r_ay_hi     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;

    // Item registers
    logic               r_op, r_pv;
    logic signed [18:0] r_x, r_y, r_z;
    logic [AW-1:0]      r_addr, r_clr;
    logic               r_kept;
    logic [37:0]        r_r2;
    logic [35:0]        r_min2, r_max2;
    logic [4:0]         r_cnt;
    logic [38:0]        r_sv, r_sr, r_sbit;
    logic signed [37:0] r_cx, r_cy;
    logic [31:0]        r_ang;
    logic               r_out_valid;
    logic               r_o_kept, r_o_hit;
    logic [17:0]        r_o_range;

    // RAM entry: {written, minimum range}
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [18:0]   ram_wdata, ram_rdata;

    pfsb_ram #(.WIDTH(19), .DEPTH(NUM_BINS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Filters on the registered point
    logic signed [20:0] x21, y21, m21, axh, ayh;
    logic               in_ground, near_wall, keep;
    assign x21 = 21'(r_x);
    assign y21 = 21'(r_y);
    assign m21 = 21'(signed'({1'b0, r_margin}));
    assign axh = 21'(r_ax_hi);
    assign ayh = 21'(r_ay_hi);
    assign in_ground = (r_z >= r_gnd_lo) && (r_z <= r_gnd_hi);
    assign near_wall =
        ((x21 >= XL - m21) && (x21 <= axh + m21) &&
         ((y21 <= YL + m21) || (y21 >= ayh - m21))) ||
        ((y21 >= YL - m21) && (y21 <= ayh + m21) &&
         ((x21 <= XL + m21) || (x21 >= axh - m21)));
    assign keep = r_pv && !in_ground && !near_wall;

    // Squares
    logic signed [37:0] xsq, ysq;
    assign xsq = r_x * r_x;
    assign ysq = r_y * r_y;

    // Range decision and exact angle-pi case
    logic binnable;
    assign binnable = r_kept && !(r_r2 < 38'(r_min2)) && !(r_r2 > 38'(r_max2)) &&
                      !(r_y == 19'sd0 && r_x < 19'sd0);

    // Square-root step
    logic [38:0] s_try;
    assign s_try = r_sr + r_sbit;

    // CORDIC step
    logic signed [37:0] dx, dy;
    assign dx = r_cy >>> r_cnt;
    assign dy = r_cx >>> r_cnt;

    // Bin index from the angle turned by a half turn, modulo one full turn
    logic [31:0] ang_u;
    logic [44:0] bprod;
    logic [12:0] bidx;
    assign ang_u = r_ang + 32'h80000000;
    assign bprod = 45'(ang_u) * 45'(NB);
    assign bidx  = bprod[44:32];

    logic out_free, sel_ok, done_calc;
    assign out_free  = !r_out_valid || i_out_ready;
    assign sel_ok    = 32'(i_bin_select) < 32'(NUM_BINS);
    assign done_calc = r_cnt == 5'(CORDIC_STEPS - 1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(NUM_BINS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_POINT) n_state = ST_CHECK;
                    else if (sel_ok)          n_state = ST_RD;
                    else                      n_state = ST_WR;
                end
            end
            ST_CHECK: n_state = ST_RANGE;
            ST_RANGE: n_state = binnable ? ST_CALC : ST_WR;
            ST_CALC:  if (done_calc) n_state = ST_BIN;
            ST_BIN:   n_state = (bidx < NB) ? ST_RD : ST_WR;
            ST_RD:    n_state = ST_WR;
            ST_WR:    if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs and memory write
    logic rmw;  // write state reached through a memory read
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = 19'd0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            ST_WR: begin
                if (out_free && rmw) begin
                    if (r_op == OP_READ) begin
                        ram_we = 1'b1;
                    end else if (!ram_rdata[18] || r_sr[17:0] < ram_rdata[17:0]) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_sr[17:0]};
                    end
                end
            end
            default: ;
        endcase
    end

    logic r_rmw;
    assign rmw = r_rmw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_rmw       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            // result posted on completion, dropped on transfer
            if (r_state == ST_WR && out_free) r_out_valid <= 1'b1;
            else if (i_out_ready)             r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_op   <= i_opcode;
                    r_pv   <= i_point_valid;
                    r_x    <= i_x_mm;
                    r_y    <= i_y_mm;
                    r_z    <= i_z_mm;
                    r_addr <= AW'(i_bin_select);
                    r_rmw  <= sel_ok;
                end
                ST_CHECK: begin
                    r_kept <= keep;
                    r_r2   <= 38'(xsq) + 38'(ysq);
                    r_min2 <= r_range_min * r_range_min;
                    r_max2 <= r_range_max * r_range_max;
                    r_rmw  <= 1'b0;
                end
                ST_RANGE: begin
                    r_cnt  <= '0;
                    r_sv   <= 39'(r_r2);
                    r_sr   <= '0;
                    r_sbit <= 39'(1) << 36;
                    if (r_x == 19'sd0) begin
                        // on the y axis: angle fixed, no rotation
                        r_cx  <= '0;
                        r_cy  <= '0;
                        r_ang <= (r_y > 19'sd0) ? 32'h40000000 :
                                 (r_y < 19'sd0) ? 32'hC0000000 : 32'h0;
                    end else if (r_x < 19'sd0) begin
                        r_cx  <= -(38'(r_x) <<< 16);
                        r_cy  <= -(38'(r_y) <<< 16);
                        r_ang <= 32'h80000000;
                    end else begin
                        r_cx  <= 38'(r_x) <<< 16;
                        r_cy  <= 38'(r_y) <<< 16;
                        r_ang <= 32'h0;
                    end
                end
                ST_CALC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt < 5'(SQRT_STEPS)) begin
                        if (r_sv >= s_try) begin
                            r_sv <= r_sv - s_try;
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                    if (r_cy > 38'sd0) begin
                        r_cx  <= r_cx + dx;
                        r_cy  <= r_cy - dy;
                        r_ang <= r_ang + atan_turn(r_cnt);
                    end else if (r_cy < 38'sd0) begin
                        r_cx  <= r_cx - dx;
                        r_cy  <= r_cy + dy;
                        r_ang <= r_ang - atan_turn(r_cnt);
                    end
                end
                ST_BIN: begin
                    r_addr <= bidx[AW-1:0];
                    r_rmw  <= bidx < NB;
                end
                ST_WR: begin
                    if (out_free) begin
                        if (r_op == OP_READ) begin
                            r_o_kept  <= 1'b0;
                            r_o_hit   <= r_rmw && ram_rdata[18];
                            r_o_range <= (r_rmw && ram_rdata[18]) ? ram_rdata[17:0]
                                                                   : r_range_max;
                        end else begin
                            r_o_kept  <= r_kept;
                            r_o_hit   <= 1'b0;
                            r_o_range <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_kept   = r_o_kept;
    assign o_bin_range_mm = r_o_range;
    assign o_bin_hit      = r_o_hit;

    // Checks
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("input taken during clearing pass");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in flight");
    a_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_WR))
        else $error("bin memory written outside clear or write-back");
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not posted on completion");

endmodule
`default_nettype wire
